### rtl/ppurp_pkg.sv
// Shared types, register codes and the constant table of the picture-unit register port.
package ppurp_pkg;

    // Access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Register numbers in the eight-register window
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMA   = 3'd3;
    localparam logic [2:0] REG_OAMD   = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam int PAL_DEPTH = 32;

    // Palette contents after power-up.
    localparam logic [7:0] POWER_PALETTE [PAL_DEPTH] = '{
        8'h09, 8'h01, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h0D,
        8'h08, 8'h10, 8'h08, 8'h24, 8'h00, 8'h00, 8'h04, 8'h2C,
        8'h09, 8'h01, 8'h34, 8'h03, 8'h00, 8'h04, 8'h00, 8'h14,
        8'h08, 8'h3A, 8'h00, 8'h02, 8'h00, 8'h20, 8'h2C, 8'h08
    };

    typedef struct packed {
        logic       mode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] fetched_byte;
        logic       vblank_flag;
        logic       sprite_zero_hit;
        logic       sprite_overflow;
    } access_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [14:0] current_address;
        logic [2:0]  fine_scroll_x;
        logic        address_changed;
        logic        vram_write_strobe;
        logic [13:0] vram_write_address;
        logic [7:0]  vram_write_data;
        logic [13:0] fill_address;
        logic [3:0]  control_flags;
        logic [7:0]  mask_flags;
    } result_t;

    // Palette mirroring: entries with both low bits clear fold onto entry addr & 0x0C.
    function automatic logic [4:0] pal_index(input logic [4:0] addr);
        logic [4:0] idx;
        if (addr[1:0] == 2'b00)
        begin
            idx = addr & 5'h0C;
        end
        else
        begin
            idx = addr;
        end
        return idx;
    endfunction

endpackage

### rtl/ppurp_if.sv
// Valid/ready channel interfaces for CPU accesses and their results.
interface ppurp_access_if;
    logic               valid;
    logic               ready;
    ppurp_pkg::access_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppurp_result_if;
    logic               valid;
    logic               ready;
    ppurp_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ppu_register_port_core.sv
// Top level of the picture-unit CPU register port.
//
// Each item on the access channel is one CPU read or write of one of the eight
// picture-unit registers; each produces exactly one item on the result channel,
// in order. An accepted item is held in an input register, then processed against
// the block state (addresses, scroll, toggle, buffer, flags and the 32-entry palette)
// and written to the result register; one item is taken every cycle when the result
// side keeps up. The rate of one item per cycle is set by the single pass of decode
// and update logic between those two registers. The input register still accepts a
// new item while a finished result waits, and only blocks when both are full. The
// palette is held in flip-flops that reset loads with the power-up table, so no
// clearing pass is needed. Data accesses whose address bits 13..8 are all set
// (0x3F00 to 0x3FFF, bit 14 ignored) use the palette, and palette reads also give a
// fill address with bit 12 cleared; other addresses go on the write strobe or the fill
// address for the external video memory, whose byte comes back with the read item.
module ppu_register_port_core (
    input  logic                  clk,
    input  logic                  rst_n,
    ppurp_access_if.sink          access,
    ppurp_result_if.source        result
);

    // Input stage
    logic               s1_valid_reg;
    ppurp_pkg::access_t s1_item_reg;

    // Result stage
    logic               out_valid_reg;
    ppurp_pkg::result_t out_item_reg;
    ppurp_pkg::result_t out_item_next;

    // Block state
    logic [14:0] temp_address_reg, temp_address_next;
    logic [14:0] video_address_reg, video_address_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        write_toggle_reg, write_toggle_next;
    logic        step_by_32_reg, step_by_32_next;
    logic [7:0]  data_buffer_reg, data_buffer_next;
    logic [3:0]  ctrl_bits_reg, ctrl_bits_next;
    logic [7:0]  mask_bits_reg, mask_bits_next;
    logic [7:0]  palette_reg [ppurp_pkg::PAL_DEPTH];

    logic        fire;
    logic        pal_area;
    logic [4:0]  pal_idx;
    logic        pal_we;
    logic [14:0] video_step;

    // The input stage moves on whenever the result register is free or is being taken.
    assign fire         = s1_valid_reg && (!out_valid_reg || result.ready);
    assign access.ready = !s1_valid_reg || fire;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // Address bits 13..8 all set select the palette window.
    assign pal_area   = &video_address_reg[13:8];
    assign pal_idx    = ppurp_pkg::pal_index(video_address_reg[4:0]);
    assign video_step = video_address_reg + (step_by_32_reg ? 15'd32 : 15'd1);

    always_comb
    begin
        temp_address_next  = temp_address_reg;
        video_address_next = video_address_reg;
        fine_x_next        = fine_x_reg;
        write_toggle_next  = write_toggle_reg;
        step_by_32_next    = step_by_32_reg;
        data_buffer_next   = data_buffer_reg;
        ctrl_bits_next     = ctrl_bits_reg;
        mask_bits_next     = mask_bits_reg;
        pal_we             = 1'b0;
        out_item_next      = '0;

        if (s1_item_reg.mode == ppurp_pkg::MODE_WRITE)
        begin
            unique case (s1_item_reg.reg_index)
                ppurp_pkg::REG_CTRL:
                begin
                    temp_address_next = (temp_address_reg & 15'h73FF)
                                      | {3'b000, s1_item_reg.write_data[1:0], 10'b0};
                    step_by_32_next   = s1_item_reg.write_data[2];
                    ctrl_bits_next    = {s1_item_reg.write_data[7], s1_item_reg.write_data[5],
                                         s1_item_reg.write_data[3], s1_item_reg.write_data[4]};
                end
                ppurp_pkg::REG_MASK:
                begin
                    mask_bits_next = s1_item_reg.write_data;
                end
                ppurp_pkg::REG_SCROLL:
                begin
                    if (!write_toggle_reg)
                    begin
                        temp_address_next = {temp_address_reg[14:5],
                                             s1_item_reg.write_data[7:3]};
                        fine_x_next       = s1_item_reg.write_data[2:0];
                    end
                    else
                    begin
                        temp_address_next = (temp_address_reg & 15'h0C1F)
                                          | {s1_item_reg.write_data[2:0], 12'b0}
                                          | {5'b0, s1_item_reg.write_data[7:3], 5'b0};
                    end
                    write_toggle_next = !write_toggle_reg;
                end
                ppurp_pkg::REG_ADDR:
                begin
                    if (!write_toggle_reg)
                    begin
                        temp_address_next = {1'b0, s1_item_reg.write_data[5:0],
                                             temp_address_reg[7:0]};
                    end
                    else
                    begin
                        temp_address_next  = {temp_address_reg[14:8], s1_item_reg.write_data};
                        video_address_next = {temp_address_reg[14:8], s1_item_reg.write_data};
                        out_item_next.address_changed = 1'b1;
                    end
                    write_toggle_next = !write_toggle_reg;
                end
                ppurp_pkg::REG_DATA:
                begin
                    out_item_next.vram_write_address = video_address_reg[13:0];
                    out_item_next.vram_write_data    = s1_item_reg.write_data;
                    out_item_next.vram_write_strobe  = !pal_area;
                    pal_we                           = pal_area;
                    video_address_next               = video_step;
                    out_item_next.address_changed    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (s1_item_reg.reg_index)
                ppurp_pkg::REG_STATUS:
                begin
                    out_item_next.read_data = {s1_item_reg.vblank_flag,
                                               s1_item_reg.sprite_zero_hit,
                                               s1_item_reg.sprite_overflow, 5'b0};
                    write_toggle_next = 1'b0;
                end
                ppurp_pkg::REG_DATA:
                begin
                    if (pal_area)
                    begin
                        // Grayscale keeps only the luminance bits.
                        out_item_next.read_data = palette_reg[pal_idx]
                                                & (mask_bits_reg[0] ? 8'h30 : 8'h3F);
                        out_item_next.fill_address = video_address_reg[13:0] & 14'h2FFF;
                    end
                    else
                    begin
                        out_item_next.read_data    = data_buffer_reg;
                        out_item_next.fill_address = video_address_reg[13:0];
                    end
                    data_buffer_next              = s1_item_reg.fetched_byte;
                    video_address_next            = video_step;
                    out_item_next.address_changed = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        out_item_next.current_address = video_address_next;
        out_item_next.fine_scroll_x   = fine_x_next;
        out_item_next.control_flags   = ctrl_bits_next;
        out_item_next.mask_flags      = mask_bits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            temp_address_reg  <= '0;
            video_address_reg <= '0;
            fine_x_reg        <= '0;
            write_toggle_reg  <= 1'b0;
            step_by_32_reg    <= 1'b0;
            data_buffer_reg   <= '0;
            ctrl_bits_reg     <= '0;
            mask_bits_reg     <= '0;
            for (int i = 0; i < ppurp_pkg::PAL_DEPTH; i++)
            begin
                palette_reg[i] <= ppurp_pkg::POWER_PALETTE[i];
            end
        end
        else
        begin
            if (access.ready)
            begin
                s1_valid_reg <= access.valid;
            end
            if (fire)
            begin
                out_valid_reg     <= 1'b1;
                temp_address_reg  <= temp_address_next;
                video_address_reg <= video_address_next;
                fine_x_reg        <= fine_x_next;
                write_toggle_reg  <= write_toggle_next;
                step_by_32_reg    <= step_by_32_next;
                data_buffer_reg   <= data_buffer_next;
                ctrl_bits_reg     <= ctrl_bits_next;
                mask_bits_reg     <= mask_bits_next;
                if (pal_we)
                begin
                    palette_reg[pal_idx] <= s1_item_reg.write_data;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (access.valid && access.ready)
        begin
            s1_item_reg <= access.payload;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

### rtl/ppurp_checker.sv
// Port-level assertions for the register port, bound to the top level.
module ppurp_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input ppurp_pkg::result_t out_payload
);

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result item changed while stalled");

    // An external write is a data access: it moves the address and returns nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.vram_write_strobe |->
            out_payload.address_changed && out_payload.read_data == 8'h00)
        else $error("write strobe without address step or with read data");

    // A refill address only comes with a data read.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.fill_address != 14'h0000 |->
            out_payload.address_changed && !out_payload.vram_write_strobe)
        else $error("fill address on an access that is not a data read");

    // Accesses that leave the address alone carry no memory traffic.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.address_changed |->
            out_payload.vram_write_address == 14'h0000
            && out_payload.fill_address == 14'h0000
            && !out_payload.vram_write_strobe)
        else $error("memory traffic without an address change");

endmodule

bind ppu_register_port_core ppurp_port_checker u_ppurp_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);
